FILE: src/tehp_pkg.sv
`timescale 1ns / 1ps
package tehp_pkg;

  // Operation codes
  localparam logic [1:0] OP_PUSH    = 2'd0;
  localparam logic [1:0] OP_POP     = 2'd1;
  localparam logic [1:0] OP_ADVANCE = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_REFUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] delay;
    logic [15:0] item_id;
  } cmd_t;

  typedef struct packed {
    logic [63:0] event_time;
    logic [15:0] event_id;
    logic [1:0]  status;
    logic [7:0]  entries;
  } evt_t;

endpackage

FILE: src/timed_event_min_heap.sv
`timescale 1ns / 1ps
// Event scheduler: a one-based binary min-heap of pending events keyed on
// absolute due time, kept in a synchronous memory with two read ports.
// Command items arrive on cmd (valid/ready): push an id due at current time
// plus delay, pop the earliest event, or advance the idle time while empty.
// Each command gives exactly one item on evt (valid/ready) carrying the due
// or current time, the popped id, a status code and the number of pending
// events afterwards.
// Commands are taken one at a time. Advance, reserved codes, a push into an
// empty or full heap and a pop from an empty heap go straight from accept
// to the finish state, which loads the result register. Any other push
// takes one compare step per level it climbs; a pop reads the root and the
// last entry, then takes one compare step per level it descends, at worst
// about log2 of QUEUE_DEPTH levels. The block returns to idle before the
// next command is taken. Each heap level in the sift loops costs one registered memory read.
// The result register holds its item until evt_ready; meanwhile the next
// command may be accepted and worked on, and it waits at its end for the
// register to free.
// Reset empties the heap and clears current time; the heap memory itself
// is not cleared, as the value of an unwritten slot is never used.
module timed_event_min_heap
  import tehp_pkg::*;
#(
  parameter int QUEUE_DEPTH = 128,
  parameter int ID_BITS     = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic evt_valid,
  input  logic evt_ready,
  output evt_t evt
);

  localparam int AW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_PUSH_CMP = 3'd1;
  localparam logic [2:0] S_POP_RD   = 3'd2;
  localparam logic [2:0] S_DOWN_CMP = 3'd3;
  localparam logic [2:0] S_PLACE    = 3'd4;
  localparam logic [2:0] S_FINISH   = 3'd5;

  // Heap storage, one-based; slot 0 unused
  logic [63:0]        mem_time [0:QUEUE_DEPTH];
  logic [ID_BITS-1:0] mem_id   [0:QUEUE_DEPTH];

  logic [2:0]         state, state_next;
  logic [AW-1:0]      count, count_next;
  logic [63:0]        cur_time, cur_time_next;
  logic [AW-1:0]      pos, pos_next;
  logic [63:0]        mv_time, mv_time_next;
  logic [ID_BITS-1:0] mv_id, mv_id_next;
  logic [63:0]        res_time, res_time_next;
  logic [15:0]        res_id, res_id_next;
  logic [1:0]         res_status, res_status_next;

  logic               rd_en;
  logic [AW-1:0]      rd_addr_a, rd_addr_b;
  logic [63:0]        rd_time_a, rd_time_b;
  logic [ID_BITS-1:0] rd_id_a, rd_id_b;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [63:0]        wr_time;
  logic [ID_BITS-1:0] wr_id;

  logic [63:0]        due;
  logic [AW-1:0]      push_pos;
  logic [AW-1:0]      parent;
  logic [AW:0]        child, child_r;
  logic               take_r;
  logic [AW-1:0]      sel_pos;
  logic [63:0]        sel_time;
  logic [ID_BITS-1:0] sel_id;
  logic [AW:0]        sel_child, sel_child_r;
  logic               out_load;

  assign cmd_ready = (state == S_IDLE);
  assign out_load  = (state == S_FINISH) && (!evt_valid || evt_ready);

  assign due      = cur_time + {32'd0, cmd.delay};
  assign push_pos = count + AW'(1);
  assign parent   = pos >> 1;

  // Pick the earlier child; the right one only if strictly earlier
  assign child       = {pos, 1'b0};
  assign child_r     = child | (AW + 1)'(1);
  assign take_r      = (child_r <= {1'b0, count}) && (rd_time_b < rd_time_a);
  assign sel_pos     = take_r ? child_r[AW-1:0] : child[AW-1:0];
  assign sel_time    = take_r ? rd_time_b : rd_time_a;
  assign sel_id      = take_r ? rd_id_b : rd_id_a;
  assign sel_child   = {sel_pos, 1'b0};
  assign sel_child_r = sel_child | (AW + 1)'(1);

  // Sequence the heap walk
  always_comb begin
    state_next      = state;
    count_next      = count;
    cur_time_next   = cur_time;
    pos_next        = pos;
    mv_time_next    = mv_time;
    mv_id_next      = mv_id;
    res_time_next   = res_time;
    res_id_next     = res_id;
    res_status_next = res_status;
    rd_en           = 1'b0;
    rd_addr_a       = '0;
    rd_addr_b       = '0;
    wr_en           = 1'b0;
    wr_addr         = pos;
    wr_time         = mv_time;
    wr_id           = mv_id;

    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          res_id_next     = '0;
          res_status_next = ST_OK;
          res_time_next   = cur_time;
          state_next      = S_FINISH;
          case (cmd.opcode)
            OP_PUSH: begin
              res_time_next = due;
              if (count == AW'(QUEUE_DEPTH)) begin
                res_status_next = ST_FULL;
              end else begin
                count_next   = push_pos;
                mv_time_next = due;
                mv_id_next   = ID_BITS'(cmd.item_id);
                pos_next     = push_pos;
                if (count == '0) begin
                  wr_en   = 1'b1;
                  wr_addr = AW'(1);
                  wr_time = due;
                  wr_id   = ID_BITS'(cmd.item_id);
                end else begin
                  rd_en      = 1'b1;
                  rd_addr_a  = push_pos >> 1;
                  state_next = S_PUSH_CMP;
                end
              end
            end
            OP_POP: begin
              if (count == '0) begin
                res_status_next = ST_EMPTY;
              end else begin
                rd_en      = 1'b1;
                rd_addr_a  = AW'(1);
                rd_addr_b  = count;
                count_next = count - AW'(1);
                state_next = S_POP_RD;
              end
            end
            OP_ADVANCE: begin
              if (count == '0) begin
                cur_time_next = due;
                res_time_next = due;
              end else begin
                res_status_next = ST_REFUSED;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Move a later parent down, or drop the new entry in place
      S_PUSH_CMP: begin
        wr_en = 1'b1;
        if (rd_time_a > mv_time) begin
          wr_time  = rd_time_a;
          wr_id    = rd_id_a;
          pos_next = parent;
          if (parent > AW'(1)) begin
            rd_en     = 1'b1;
            rd_addr_a = parent >> 1;
          end else begin
            state_next = S_PLACE;
          end
        end else begin
          state_next = S_FINISH;
        end
      end

      // Root and last entry are back: report the root, sift the last down
      S_POP_RD: begin
        res_time_next = rd_time_a;
        res_id_next   = 16'(rd_id_a);
        cur_time_next = rd_time_a;
        mv_time_next  = rd_time_b;
        mv_id_next    = rd_id_b;
        pos_next      = AW'(1);
        if ((AW + 1)'(2) <= {1'b0, count}) begin
          rd_en      = 1'b1;
          rd_addr_a  = AW'(2);
          rd_addr_b  = ((AW + 1)'(3) <= {1'b0, count}) ? AW'(3) : '0;
          state_next = S_DOWN_CMP;
        end else begin
          state_next = S_PLACE;
        end
      end

      // Lift the earlier child, or drop the moved entry here
      S_DOWN_CMP: begin
        wr_en = 1'b1;
        if (mv_time <= sel_time) begin
          state_next = S_FINISH;
        end else begin
          wr_time  = sel_time;
          wr_id    = sel_id;
          pos_next = sel_pos;
          if (sel_child <= {1'b0, count}) begin
            rd_en     = 1'b1;
            rd_addr_a = sel_child[AW-1:0];
            rd_addr_b = (sel_child_r <= {1'b0, count}) ? sel_child_r[AW-1:0] : '0;
          end else begin
            state_next = S_PLACE;
          end
        end
      end

      S_PLACE: begin
        wr_en      = 1'b1;
        state_next = S_FINISH;
      end

      S_FINISH: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Heap memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_time[wr_addr] <= wr_time;
      mem_id[wr_addr]   <= wr_id;
    end
    if (rd_en) begin
      rd_time_a <= mem_time[rd_addr_a];
      rd_id_a   <= mem_id[rd_addr_a];
      rd_time_b <= mem_time[rd_addr_b];
      rd_id_b   <= mem_id[rd_addr_b];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      cur_time <= '0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      cur_time <= cur_time_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    pos        <= pos_next;
    mv_time    <= mv_time_next;
    mv_id      <= mv_id_next;
    res_time   <= res_time_next;
    res_id     <= res_id_next;
    res_status <= res_status_next;
  end

  // Hold the result item until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      evt_valid <= 1'b0;
    end else if (out_load) begin
      evt_valid <= 1'b1;
    end else if (evt_ready) begin
      evt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      evt.event_time <= res_time;
      evt.event_id   <= res_id;
      evt.status     <= res_status;
      evt.entries    <= 8'(count);
    end
  end

endmodule

FILE: sim/tb_timed_event_min_heap.sv
`timescale 1ns / 1ps
module tb_timed_event_min_heap
  import tehp_pkg::*;
;

  localparam logic [1:0] OP_RESERVED = 2'd3;
  localparam int         CYCLE_LIMIT = 500000;
  localparam int         RAND_ITEMS  = 500;

  // Traffic mixes for the random part
  typedef enum int {MIX_PUSHY, MIX_POPPY, MIX_EVEN} mix_t;

  // Heap model and store of expected result items
  class event_queue_model;
    localparam int DEPTH = 128;

    logic [63:0] slot_time [1:DEPTH];
    logic [15:0] slot_id   [1:DEPTH];
    int unsigned depth_used;
    logic [63:0] now_ps;
    evt_t        due_results [$];
    int          errors;

    function new();
      depth_used = 0;
      now_ps     = '0;
      errors     = 0;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    // Sift a new entry up past strictly later parents
    function void heap_insert(logic [63:0] due, logic [15:0] id);
      int unsigned pos;
      depth_used++;
      pos = depth_used;
      while (pos > 1 && slot_time[pos >> 1] > due) begin
        slot_time[pos] = slot_time[pos >> 1];
        slot_id[pos]   = slot_id[pos >> 1];
        pos = pos >> 1;
      end
      slot_time[pos] = due;
      slot_id[pos]   = id;
    endfunction

    // Move the last entry to the root and sift it down
    function void heap_remove_root();
      logic [63:0] mt;
      logic [15:0] mid;
      int unsigned pos;
      int unsigned child;
      mt  = slot_time[depth_used];
      mid = slot_id[depth_used];
      depth_used--;
      pos = 1;
      while ((pos << 1) <= depth_used) begin
        child = pos << 1;
        if (child + 1 <= depth_used && slot_time[child + 1] < slot_time[child]) begin
          child++;
        end
        if (mt <= slot_time[child]) break;
        slot_time[pos] = slot_time[child];
        slot_id[pos]   = slot_id[child];
        pos = child;
      end
      slot_time[pos] = mt;
      slot_id[pos]   = mid;
    endfunction

    // Work out the result of an accepted command item and queue it
    function void note_cmd(cmd_t c);
      evt_t        r;
      logic [63:0] due;
      r.event_time = now_ps;
      r.event_id   = '0;
      r.status     = ST_OK;
      case (c.opcode)
        OP_PUSH: begin
          due          = now_ps + 64'(c.delay);
          r.event_time = due;
          if (depth_used >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            heap_insert(due, c.item_id);
          end
        end
        OP_POP: begin
          if (depth_used == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.event_time = slot_time[1];
            r.event_id   = slot_id[1];
            now_ps       = slot_time[1];
            heap_remove_root();
          end
        end
        OP_ADVANCE: begin
          if (depth_used == 0) begin
            now_ps       = now_ps + 64'(c.delay);
            r.event_time = now_ps;
          end else begin
            r.status = ST_REFUSED;
          end
        end
        default: begin
        end
      endcase
      r.entries = 8'(depth_used);
      due_results = {due_results, r};
    endfunction

    // Compare a result item with the oldest expectation
    function void check_evt(evt_t got);
      evt_t want;
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("ERROR: unexpected result time=%0d id=%h status=%0d entries=%0d",
                   got.event_time, got.event_id, got.status, got.entries);
        end
        return;
      end
      want = due_results.pop_front();
      if (got.event_time !== want.event_time || got.event_id !== want.event_id ||
          got.status !== want.status || got.entries !== want.entries) begin
        errors++;
        if (errors <= 10) begin
          $display("ERROR: result mismatch");
          $display("  time    exp %0d got %0d", want.event_time, got.event_time);
          $display("  id      exp %h got %h", want.event_id, got.event_id);
          $display("  status  exp %0d got %0d", want.status, got.status);
          $display("  entries exp %0d got %0d", want.entries, got.entries);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;
  logic evt_valid;
  logic evt_ready;
  evt_t evt;

  event_queue_model sb = new();
  bit               no_idle;
  int               cycles;

  timed_event_min_heap u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .evt_valid (evt_valid),
    .evt_ready (evt_ready),
    .evt       (evt)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Abort a run that hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Check every result item taken from the block
  always @(posedge clk) begin
    if (!rst && evt_valid && evt_ready) begin
      sb.check_evt(evt);
    end
  end

  // Gap length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Delay: biased to small values so that due times tie often
  function automatic logic [31:0] rand_delay();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 32'($urandom_range(0, 3));
      4, 5:       return 32'($urandom_range(0, 1000));
      6, 7:       return $urandom;
      8:          return 32'hFFFF_FFFF;
      default:    return 32'd0;
    endcase
  endfunction

  function automatic cmd_t make_cmd(logic [1:0] op, logic [31:0] dly, logic [15:0] id);
    cmd_t c;
    c.opcode  = op;
    c.delay   = dly;
    c.item_id = id;
    return c;
  endfunction

  function automatic cmd_t rand_cmd(mix_t mix);
    int          r;
    int          push_pct;
    int          pop_pct;
    logic [1:0]  op;
    push_pct = (mix == MIX_PUSHY) ? 70 : (mix == MIX_POPPY) ? 25 : 45;
    pop_pct  = (mix == MIX_PUSHY) ? 25 : (mix == MIX_POPPY) ? 70 : 45;
    r = $urandom_range(0, 99);
    if (r < push_pct) op = OP_PUSH;
    else if (r < push_pct + pop_pct) op = OP_POP;
    else if ($urandom_range(0, 3) != 0) op = OP_ADVANCE;
    else op = OP_RESERVED;
    return make_cmd(op, rand_delay(), 16'($urandom_range(0, 65535)));
  endfunction

  // Offer one command item and hold it until accepted
  task automatic send_cmd(input cmd_t c);
    int gap;
    gap = no_idle ? 0 : idle_len();
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= c;
    do @(posedge clk); while (!cmd_ready);
    sb.note_cmd(c);
  endtask

  // Hold off the sender until every expected result has come
  task automatic wait_drained();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Result side: stall at random, with calm stretches
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      stall = no_idle ? 0 : idle_len();
      if (stall > 0) begin
        evt_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      evt_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  initial begin
    int   sent;
    mix_t mix;
    rst       <= 1'b1;
    cmd_valid <= 1'b0;
    cmd       <= '0;
    evt_ready <= 1'b0;
    cycles    <= 0;
    no_idle   = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty pop, advances, reserved code, extremes and ties
    send_cmd(make_cmd(OP_POP,      32'd0,          16'h0000));
    send_cmd(make_cmd(OP_ADVANCE,  32'd0,          16'h0000));
    send_cmd(make_cmd(OP_ADVANCE,  32'd1000,       16'hFFFF));
    send_cmd(make_cmd(OP_RESERVED, 32'd0,          16'h0000));
    send_cmd(make_cmd(OP_PUSH,     32'd0,          16'h0000));
    send_cmd(make_cmd(OP_PUSH,     32'hFFFF_FFFF,  16'hFFFF));
    send_cmd(make_cmd(OP_PUSH,     32'd5,          16'h1234));
    send_cmd(make_cmd(OP_PUSH,     32'd5,          16'h4321));
    send_cmd(make_cmd(OP_PUSH,     32'd0,          16'hAAAA));
    send_cmd(make_cmd(OP_ADVANCE,  32'd7,          16'h0000));
    send_cmd(make_cmd(OP_RESERVED, 32'hFFFF_FFFF,  16'hFFFF));
    repeat (5) send_cmd(make_cmd(OP_POP, 32'hFFFF_FFFF, 16'hFFFF));
    send_cmd(make_cmd(OP_POP,      32'd0,          16'h0000));
    send_cmd(make_cmd(OP_ADVANCE,  32'hFFFF_FFFF,  16'h0000));
    send_cmd(make_cmd(OP_PUSH,     32'd0,          16'h5555));
    send_cmd(make_cmd(OP_PUSH,     32'd3,          16'h0F0F));
    send_cmd(make_cmd(OP_PUSH,     32'd3,          16'hF0F0));
    repeat (3) send_cmd(make_cmd(OP_POP, 32'd0, 16'h0000));
    wait_drained();

    // Random: shifting mixes, one fill to full and drain to empty
    sent = 0;
    mix  = MIX_EVEN;
    while (sent < RAND_ITEMS) begin
      if (sent % 40 == 0) begin
        mix     = mix_t'($urandom_range(0, 2));
        no_idle = ($urandom_range(0, 4) == 0);
      end
      if (sent == 150) begin
        while (sb.depth_used < 128) begin
          send_cmd(make_cmd(OP_PUSH, rand_delay(), 16'($urandom)));
          sent++;
        end
        repeat (4) begin
          send_cmd(make_cmd(OP_PUSH, rand_delay(), 16'($urandom)));
          sent++;
        end
        while (sb.depth_used > 0) begin
          send_cmd(make_cmd(OP_POP, $urandom, 16'($urandom)));
          sent++;
        end
        repeat (2) begin
          send_cmd(make_cmd(OP_POP, $urandom, 16'($urandom)));
          sent++;
        end
        wait_drained();
      end
      send_cmd(rand_cmd(mix));
      sent++;
      if (sent % 120 == 0) wait_drained();
    end

    // Drain, then let any stray result show up
    wait_drained();
    repeat (40) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/tehp_pkg.sv
src/timed_event_min_heap.sv
sim/tb_timed_event_min_heap.sv
